// ----- hw/rtl/planar_frame_transform_defines.svh -----
// Assertion macros used by the checker file.
// Each macro samples on clock; the first two are off while reset is high.
`ifndef PLANAR_FRAME_TRANSFORM_DEFINES_SVH
`define PLANAR_FRAME_TRANSFORM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define PFT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Same as PFT_ASSERT_NEXT but also checked across reset
`define PFT_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/pft_pkg.sv -----
package pft_pkg;

   // Rotation stages; counts above 32 act as 32
   localparam int CORDIC_STAGES = 20;
   localparam int CORDIC_DEPTH  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

   // Datapath widths
   localparam int COORD_W    = 32;               // Q15.16 coordinate
   localparam int DIFF_W     = COORD_W + 1;      // point minus origin
   localparam int ANGLE_W    = 32;               // binary angle
   localparam int TRIG_W     = 32;               // Q1.30 cosine and sine
   localparam int FRAC_SHIFT = 30;
   localparam int PROD_W     = DIFF_W + TRIG_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int RND_W      = SUM_W - FRAC_SHIFT;
   localparam int RES_W      = RND_W + 1;

   localparam logic signed [TRIG_W-1:0] GAIN_Q30   = 32'sd652032874;
   localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(64'sd536870912);
   localparam logic [ANGLE_W-1:0]       QUAD_BIAS  = 32'h2000_0000;

   // Actions
   localparam logic ACT_TO_GLOBAL = 1'b0;
   localparam logic ACT_TO_LOCAL  = 1'b1;

   // Nearest quadrant of the heading
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic                      action;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [ANGLE_W-1:0]        heading;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
   } pft_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic                      overflow;
   } pft_rsp_type;

   // Operands carried alongside the rotation
   typedef struct packed {
      logic                      action;
      logic signed [DIFF_W-1:0]  a;
      logic signed [DIFF_W-1:0]  b;
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic [1:0]                quad;
   } pft_side_type;

   typedef struct packed {
      pft_side_type              side;
      logic signed [TRIG_W-1:0]  x;
      logic signed [TRIG_W-1:0]  y;
      logic signed [ANGLE_W-1:0] z;
   } pft_rot_type;

   // atan(2^-idx) in binary angle units, rounded
   function automatic logic [ANGLE_W-1:0] atan_angle(input logic [4:0] idx);
      logic [ANGLE_W-1:0] val;
      unique case (idx)
         5'd0:  val = 32'h2000_0000;
         5'd1:  val = 32'h12E4_051E;
         5'd2:  val = 32'h09FB_385B;
         5'd3:  val = 32'h0511_11D4;
         5'd4:  val = 32'h028B_0D43;
         5'd5:  val = 32'h0145_D7E1;
         5'd6:  val = 32'h00A2_F61E;
         5'd7:  val = 32'h0051_7C55;
         5'd8:  val = 32'h0028_BE53;
         5'd9:  val = 32'h0014_5F2F;
         5'd10: val = 32'h000A_2F98;
         5'd11: val = 32'h0005_17CC;
         5'd12: val = 32'h0002_8BE6;
         5'd13: val = 32'h0001_45F3;
         5'd14: val = 32'h0000_A2FA;
         5'd15: val = 32'h0000_517D;
         5'd16: val = 32'h0000_28BE;
         5'd17: val = 32'h0000_145F;
         5'd18: val = 32'h0000_0A30;
         5'd19: val = 32'h0000_0518;
         5'd20: val = 32'h0000_028C;
         5'd21: val = 32'h0000_0146;
         5'd22: val = 32'h0000_00A3;
         5'd23: val = 32'h0000_0051;
         5'd24: val = 32'h0000_0029;
         5'd25: val = 32'h0000_0014;
         5'd26: val = 32'h0000_000A;
         5'd27: val = 32'h0000_0005;
         5'd28: val = 32'h0000_0003;
         5'd29: val = 32'h0000_0001;
         5'd30: val = 32'h0000_0001;
         5'd31: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

// ----- hw/rtl/planar_frame_transform.sv -----
// Planar rigid transform of one point per transaction. Action 0 maps a local
// point to the global frame (origin plus the point rotated by the heading);
// action 1 maps a global point to the local frame (point minus origin,
// rotated by minus the heading). Coordinates are signed Q15.16, the heading
// is a 32-bit binary angle, and results saturate with overflow raised. The
// block is fully pipelined: one transaction enters per cycle unless a full
// pipeline is stalled on rsp_ready. From acceptance to a valid response a
// transaction passes one register per CORDIC micro-rotation (CORDIC_STAGES,
// 20 by default; counts above 32 act as 32) plus prepare, quadrant fix,
// multiply, sum and saturate stages. Ready ripples back stage by stage, so
// idle slots are filled while a finished response waits on rsp_ready.
module planar_frame_transform
   import pft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pft_req_type req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pft_rsp_type rsp
);

   typedef struct packed {
      pft_side_type             side;
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] s;
   } pft_trig_type;

   typedef struct packed {
      logic                      action;
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [PROD_W-1:0]  ac;
      logic signed [PROD_W-1:0]  bs;
      logic signed [PROD_W-1:0]  as;
      logic signed [PROD_W-1:0]  bc;
   } pft_prod_type;

   typedef struct packed {
      logic                      action;
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [RND_W-1:0]   rx;
      logic signed [RND_W-1:0]   ry;
   } pft_sum_type;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

   logic         prep_valid_ff;
   pft_rot_type  prep_ff;
   pft_rot_type  prep_in;
   logic         prep_ready;
   logic [ANGLE_W-1:0] biased;
   logic [1:0]   quad;

   logic         cordic_in_ready;
   logic         cordic_valid;
   pft_rot_type  cordic_data;

   logic         fix_valid_ff;
   pft_trig_type fix_ff;
   pft_trig_type fix_in;
   logic         fix_ready;

   logic         mul_valid_ff;
   pft_prod_type mul_ff;
   pft_prod_type mul_in;
   logic         mul_ready;

   logic         sum_valid_ff;
   pft_sum_type  sum_ff;
   pft_sum_type  sum_in;
   logic         sum_ready;
   logic signed [SUM_W-1:0] sum_x;
   logic signed [SUM_W-1:0] sum_y;

   logic         rsp_valid_ff;
   pft_rsp_type  rsp_ff;
   pft_rsp_type  rsp_in;
   logic         out_ready;
   logic signed [RES_W-1:0] res_x;
   logic signed [RES_W-1:0] res_y;
   logic         fit_x;
   logic         fit_y;

   // Ready chain: each stage moves when empty or when drained downstream
   assign out_ready  = !rsp_valid_ff || rsp_ready;
   assign sum_ready  = !sum_valid_ff || out_ready;
   assign mul_ready  = !mul_valid_ff || sum_ready;
   assign fix_ready  = !fix_valid_ff || mul_ready;
   assign prep_ready = !prep_valid_ff || cordic_in_ready;
   assign req_ready  = prep_ready;

   // Prepare: nearest quadrant, residual angle and, for to-local, operand differences
   assign biased = req.heading + QUAD_BIAS;
   assign quad   = biased[ANGLE_W-1:ANGLE_W-2];

   always_comb begin
      prep_in.side.action = req.action;
      prep_in.side.ox     = req.origin_x;
      prep_in.side.oy     = req.origin_y;
      prep_in.side.quad   = quad;
      if (req.action == ACT_TO_LOCAL) begin
         prep_in.side.a = DIFF_W'(req.point_x) - DIFF_W'(req.origin_x);
         prep_in.side.b = DIFF_W'(req.point_y) - DIFF_W'(req.origin_y);
      end else begin
         prep_in.side.a = DIFF_W'(req.point_x);
         prep_in.side.b = DIFF_W'(req.point_y);
      end
      prep_in.x = GAIN_Q30;
      prep_in.y = '0;
      prep_in.z = $signed(req.heading - {quad, {(ANGLE_W - 2){1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (prep_ready) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_ready && req_valid) begin
         prep_ff <= prep_in;
      end
   end

   pft_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid_ff),
      .in_ready  (cordic_in_ready),
      .in_data   (prep_ff),
      .out_valid (cordic_valid),
      .out_ready (fix_ready),
      .out_data  (cordic_data)
   );

   // Quadrant fix: rotate cosine and sine back by the removed quarter turns
   always_comb begin
      fix_in.side = cordic_data.side;
      unique case (cordic_data.side.quad)
         QUAD_0: begin
            fix_in.c = cordic_data.x;
            fix_in.s = cordic_data.y;
         end
         QUAD_1: begin
            fix_in.c = -cordic_data.y;
            fix_in.s = cordic_data.x;
         end
         QUAD_2: begin
            fix_in.c = -cordic_data.x;
            fix_in.s = -cordic_data.y;
         end
         QUAD_3: begin
            fix_in.c = cordic_data.y;
            fix_in.s = -cordic_data.x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_valid_ff <= 1'b0;
      end else if (fix_ready) begin
         fix_valid_ff <= cordic_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fix_ready && cordic_valid) begin
         fix_ff <= fix_in;
      end
   end

   // Multiply: four exact products of operands with cosine and sine
   always_comb begin
      mul_in.action = fix_ff.side.action;
      mul_in.ox     = fix_ff.side.ox;
      mul_in.oy     = fix_ff.side.oy;
      mul_in.ac     = PROD_W'(fix_ff.side.a) * PROD_W'(fix_ff.c);
      mul_in.bs     = PROD_W'(fix_ff.side.b) * PROD_W'(fix_ff.s);
      mul_in.as     = PROD_W'(fix_ff.side.a) * PROD_W'(fix_ff.s);
      mul_in.bc     = PROD_W'(fix_ff.side.b) * PROD_W'(fix_ff.c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= fix_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && fix_valid_ff) begin
         mul_ff <= mul_in;
      end
   end

   // Sum: combine products by direction, round to Q19.16
   always_comb begin
      if (mul_ff.action == ACT_TO_GLOBAL) begin
         sum_x = SUM_W'(mul_ff.ac) - SUM_W'(mul_ff.bs) + ROUND_HALF;
         sum_y = SUM_W'(mul_ff.as) + SUM_W'(mul_ff.bc) + ROUND_HALF;
      end else begin
         sum_x = SUM_W'(mul_ff.ac) + SUM_W'(mul_ff.bs) + ROUND_HALF;
         sum_y = SUM_W'(mul_ff.bc) - SUM_W'(mul_ff.as) + ROUND_HALF;
      end
      sum_in.action = mul_ff.action;
      sum_in.ox     = mul_ff.ox;
      sum_in.oy     = mul_ff.oy;
      sum_in.rx     = sum_x[SUM_W-1:FRAC_SHIFT];
      sum_in.ry     = sum_y[SUM_W-1:FRAC_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (sum_ready) begin
         sum_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && mul_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

   // Output: add origin for local to global, then clamp to 32 bits
   always_comb begin
      if (sum_ff.action == ACT_TO_GLOBAL) begin
         res_x = RES_W'(sum_ff.rx) + RES_W'(sum_ff.ox);
         res_y = RES_W'(sum_ff.ry) + RES_W'(sum_ff.oy);
      end else begin
         res_x = RES_W'(sum_ff.rx);
         res_y = RES_W'(sum_ff.ry);
      end
      fit_x = (&res_x[RES_W-1:COORD_W-1]) || !(|res_x[RES_W-1:COORD_W-1]);
      fit_y = (&res_y[RES_W-1:COORD_W-1]) || !(|res_y[RES_W-1:COORD_W-1]);
      if (fit_x) begin
         rsp_in.out_x = res_x[COORD_W-1:0];
      end else begin
         rsp_in.out_x = res_x[RES_W-1] ? COORD_MIN : COORD_MAX;
      end
      if (fit_y) begin
         rsp_in.out_y = res_y[COORD_W-1:0];
      end else begin
         rsp_in.out_y = res_y[RES_W-1] ? COORD_MIN : COORD_MAX;
      end
      rsp_in.overflow = !(fit_x && fit_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && sum_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- hw/rtl/pft_cordic.sv -----
module pft_cordic
   import pft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  pft_rot_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output pft_rot_type out_data
);

   logic [CORDIC_DEPTH-1:0] valid_ff;
   logic [CORDIC_DEPTH-1:0] stage_ready;
   pft_rot_type             data_ff [CORDIC_DEPTH];

   for (genvar i = 0; i < CORDIC_DEPTH; i++) begin : g_stage
      logic                     src_valid;
      logic                     down_ready;
      pft_rot_type              src;
      pft_rot_type              data_in;
      logic signed [TRIG_W-1:0] xs;
      logic signed [TRIG_W-1:0] ys;
      logic signed [ANGLE_W-1:0] step;

      // Select stage source
      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src       = in_data;
      end else begin : g_inner
         assign src_valid = valid_ff[i-1];
         assign src       = data_ff[i-1];
      end

      if (i == CORDIC_DEPTH - 1) begin : g_last
         assign down_ready = out_ready;
      end else begin : g_mid
         assign down_ready = stage_ready[i+1];
      end

      // Advance when empty or when the next stage takes our transaction
      assign stage_ready[i] = !valid_ff[i] || down_ready;

      // One micro-rotation toward zero residual angle
      assign xs   = src.x >>> i;
      assign ys   = src.y >>> i;
      assign step = $signed(atan_angle(5'(i)));

      always_comb begin
         data_in = src;
         if (!src.z[ANGLE_W-1]) begin
            data_in.x = src.x - ys;
            data_in.y = src.y + xs;
            data_in.z = src.z - step;
         end else begin
            data_in.x = src.x + ys;
            data_in.y = src.y - xs;
            data_in.z = src.z + step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (stage_ready[i]) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[i] && src_valid) begin
            data_ff[i] <= data_in;
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[CORDIC_DEPTH-1];
   assign out_data  = data_ff[CORDIC_DEPTH-1];

endmodule

// ----- hw/rtl/pft_checker.sv -----
`include "planar_frame_transform_defines.svh"

module pft_checker
   import pft_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input pft_rsp_type rsp
);

   logic out_x_clamped;
   logic out_y_clamped;

   assign out_x_clamped = (rsp.out_x == 32'sh7FFF_FFFF) || (rsp.out_x == 32'sh8000_0000);
   assign out_y_clamped = (rsp.out_y == 32'sh7FFF_FFFF) || (rsp.out_y == 32'sh8000_0000);

   // Pipeline is empty right after reset
   `PFT_ASSERT_RESET(a_empty_after_reset, reset, !rsp_valid, "response valid after reset")

   // A stalled response holds its value
   `PFT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

   // Overflow only comes with a clamped coordinate
   `PFT_ASSERT_SAME(a_overflow_clamped, rsp_valid && rsp.overflow, out_x_clamped || out_y_clamped, "overflow without clamped result")

   // With the output draining, the whole pipeline moves and takes input
   `PFT_ASSERT_SAME(a_ready_chain, rsp_ready, req_ready, "request stalled while response side is ready")

endmodule

bind planar_frame_transform pft_checker u_pft_checker (.*);
